>>> hw/rtl/acba_pkg.sv
// Shared types and constants for the CORDIC atan2 pipeline.
// Holds the stage payload struct, half-turn codes and arctangent tables.
// No dependencies.
package acba_pkg;

    // Internal x/y width: covers CORDIC gain on a full-scale negated vector
    localparam int XY_W    = 19;
    localparam int ANGLE_W = 16;
    localparam int BITS_LO = 8;
    localparam int BITS_HI = 16;
    localparam int ROM_ROWS = BITS_HI - BITS_LO + 1;
    localparam int ROM_COLS = BITS_HI - 1;

    // Half-turn correction noted by the pre-rotation
    typedef enum logic [1:0] {
        HALF_NONE,
        HALF_POS,
        HALF_NEG
    } t_half;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [ANGLE_W-1:0]     z;
        t_half                  half;
    } t_vec;

    // Arctangent entries, one row per precision, rows padded with zeros
    localparam logic [ANGLE_W-1:0] ATAN_ROM [ROM_ROWS][ROM_COLS] = '{
        '{16'h0020, 16'h0013, 16'h000A, 16'h0005, 16'h0003, 16'h0001, 16'h0001,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000},
        '{16'h0040, 16'h0026, 16'h0014, 16'h000A, 16'h0005, 16'h0003, 16'h0001,
          16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000},
        '{16'h0080, 16'h004C, 16'h0028, 16'h0014, 16'h000A, 16'h0005, 16'h0003,
          16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000},
        '{16'h0100, 16'h0097, 16'h0050, 16'h0029, 16'h0014, 16'h000A, 16'h0005,
          16'h0003, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000},
        '{16'h0200, 16'h012E, 16'h00A0, 16'h0051, 16'h0029, 16'h0014, 16'h000A,
          16'h0005, 16'h0003, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
          16'h0000},
        '{16'h0400, 16'h025D, 16'h013F, 16'h00A2, 16'h0051, 16'h0029, 16'h0014,
          16'h000A, 16'h0005, 16'h0003, 16'h0001, 16'h0001, 16'h0000, 16'h0000,
          16'h0000},
        '{16'h0800, 16'h04B9, 16'h027F, 16'h0144, 16'h00A3, 16'h0051, 16'h0029,
          16'h0014, 16'h000A, 16'h0005, 16'h0003, 16'h0001, 16'h0001, 16'h0000,
          16'h0000},
        '{16'h1000, 16'h0972, 16'h04FE, 16'h0289, 16'h0146, 16'h00A3, 16'h0051,
          16'h0029, 16'h0014, 16'h000A, 16'h0005, 16'h0003, 16'h0001, 16'h0001,
          16'h0000},
        '{16'h2000, 16'h12E4, 16'h09FB, 16'h0511, 16'h028B, 16'h0146, 16'h00A3,
          16'h0051, 16'h0029, 16'h0014, 16'h000A, 16'h0005, 16'h0003, 16'h0001,
          16'h0001}
    };

    // Look up the arctangent entry of one micro-rotation at one precision
    function automatic logic [ANGLE_W-1:0] atan_entry(input int bits, input int k);
        return ATAN_ROM[bits - BITS_LO][k];
    endfunction

endpackage

>>> hw/rtl/acba_stage.sv
// One CORDIC vectoring micro-rotation with its own pipeline register.
// Depends on acba_pkg for the payload struct.
module acba_stage #(
    parameter int          SHIFT = 0,
    parameter logic [15:0] ENTRY = 16'h2000
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  acba_pkg::t_vec i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output acba_pkg::t_vec o_data
);
    import acba_pkg::*;

    logic r_valid;
    t_vec r_data;
    t_vec n_data;

    // Take a new request when empty or when the held one moves on
    assign o_ready = !r_valid || i_ready;

    // Rotate toward y = 0 and accumulate the angle
    always_comb begin
        n_data = i_data;
        if (i_data.y <= 0) begin
            n_data.x = i_data.x - (i_data.y >>> SHIFT);
            n_data.y = i_data.y + (i_data.x >>> SHIFT);
            n_data.z = i_data.z - ENTRY;
        end else begin
            n_data.x = i_data.x + (i_data.y >>> SHIFT);
            n_data.y = i_data.y - (i_data.x >>> SHIFT);
            n_data.z = i_data.z + ENTRY;
        end
    end

    // Advance the stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

`ifndef SYNTHESIS
    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid)
        else $error("stage dropped a stalled request");
    a_hold_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> $stable(r_data))
        else $error("stage payload changed under stall");
    a_x_positive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !r_data.x[XY_W-1])
        else $error("rotated x went negative");
`endif

endmodule

>>> hw/rtl/atan2_cordic_binary_angle.sv
// Pipelined CORDIC atan2 returning a binary angle.
// Depends on acba_pkg and acba_stage.
//
// Usage:
//   Slave channel i_s_*: one (x, y) request per accepted beat.
//   Master channel o_m_*: one 16-bit binary angle per request, pi equal to
//   2^(ANGLE_BITS-1) with ANGLE_BITS clamped to 8..16, wrapping modulo
//   2^16; results leave in request order.
// Pipeline: one pre-rotation register, ANGLE_BITS-1 micro-rotation stages,
//   one output register.
// Throughput: one request per cycle when not stalled; each micro-rotation
//   has its own shift-add stage, so no unit is shared between requests.
// Stall: every stage holds a valid bit and takes a new request whenever it
//   is empty or its content moves on, so bubbles close up and the slave side
//   keeps accepting while earlier stages have room. A held result stays on
//   o_m_tdata until taken; nothing is lost or repeated.
// Reset: synchronous, active low; all valid bits clear, the pipeline is
//   empty and ready on the first cycle after reset.
module atan2_cordic_binary_angle #(
    parameter int ANGLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] x_in, [31:16] y_in
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] angle
);
    import acba_pkg::*;

    localparam int BITS = (ANGLE_BITS < BITS_LO) ? BITS_LO :
                          (ANGLE_BITS > BITS_HI) ? BITS_HI : ANGLE_BITS;
    localparam int N    = BITS - 1;
    localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(1 << (BITS - 1));

    logic                   w_valid [N+1];
    t_vec                   w_data  [N+1];
    logic                   w_rdy   [N+2];

    logic                   r_pre_valid;
    t_vec                   r_pre;
    t_vec                   n_pre;
    logic signed [XY_W-1:0] w_x;
    logic signed [XY_W-1:0] w_y;

    logic                   r_out_valid;
    logic [ANGLE_W-1:0]     r_angle;
    logic [ANGLE_W-1:0]     n_angle;

    // Pre-rotation: fold the left half-plane onto the right
    assign w_x = XY_W'(signed'(i_s_tdata[15:0]));
    assign w_y = XY_W'(signed'(i_s_tdata[31:16]));

    always_comb begin
        n_pre.z = '0;
        if (w_x < 0) begin
            n_pre.x    = -w_x;
            n_pre.y    = -w_y;
            n_pre.half = (w_y > 0) ? HALF_POS : HALF_NEG;
        end else begin
            n_pre.x    = w_x;
            n_pre.y    = w_y;
            n_pre.half = HALF_NONE;
        end
    end

    assign w_rdy[0]   = !r_pre_valid || w_rdy[1];
    assign o_s_tready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (w_rdy[0]) begin
            r_pre_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_s_tvalid) begin
            r_pre <= n_pre;
        end
    end

    assign w_valid[0] = r_pre_valid;
    assign w_data[0]  = r_pre;

    // Micro-rotation chain, one stage per arctangent entry
    for (genvar k = 0; k < N; k++) begin : g_rot
        acba_stage #(
            .SHIFT (k),
            .ENTRY (atan_entry(BITS, k))
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_rdy[k+1]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_rdy[k+2]),
            .o_data  (w_data[k+1])
        );
    end

    // Apply the half-turn correction
    always_comb begin
        unique case (w_data[N].half)
            HALF_POS: n_angle = w_data[N].z + HALF_TURN;
            HALF_NEG: n_angle = w_data[N].z - HALF_TURN;
            default:  n_angle = w_data[N].z;
        endcase
    end

    // Hold the result until the master side takes it
    assign w_rdy[N+1] = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy[N+1]) begin
            r_out_valid <= w_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[N+1] && w_valid[N]) begin
            r_angle <= n_angle;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_angle;

`ifndef SYNTHESIS
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or vanished under stall");
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("pipeline not empty after reset");
    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pre_valid |-> o_s_tready)
        else $error("empty front stage refused a request");
    a_pre_positive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pre_valid |-> !r_pre.x[XY_W-1])
        else $error("pre-rotation left x negative");
`endif

endmodule
